// ----- rtl/core/fat12_cte_pkg.sv -----
// shared types, constants and command codes for the fat12 cluster table engine
package fat12_cte_pkg;

  localparam int DEF_MAX_CLUSTERS = 4096;
  localparam int DEF_TABLE_BYTES  = 6144;

  localparam int CLUSTER_W = 12;
  localparam int ADDR_W    = 13;
  localparam int COUNT_W   = 13;
  localparam int CMD_W     = 3;

  localparam logic [ADDR_W-1:0]    LIMIT_RESET = 13'd4096;
  localparam logic [CLUSTER_W-1:0] EOC_MIN     = 12'hFF8;
  localparam logic [ADDR_W-1:0]    FIRST_DATA_CLUSTER = 13'd2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENTRY,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [CLUSTER_W-1:0] cluster;
    logic [CLUSTER_W-1:0] value;
    logic [ADDR_W-1:0]    byte_addr;
    logic [7:0]           byte_data;
  } in_item_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] next_cluster;
    logic                 end_of_chain;
    logic [CLUSTER_W-1:0] found_cluster;
    logic [COUNT_W-1:0]   free_count;
    logic                 status;
  } out_item_t;

endpackage

// ----- rtl/core/fat12_cluster_table_engine.sv -----
// fat12 allocation table held in two byte banks, with entry access and free scans
//
// The table lives in two synchronous byte memories, even byte addresses in one
// bank and odd ones in the other, so the two bytes of a 12-bit entry come out
// of one read. Load byte and unused command codes finish in the cycle they are
// accepted; read entry and write entry read on acceptance, then in the entry
// state return the entry or merge and write back. Find free and count free issue
// one entry read per cycle from cluster 2: count free reads up to the limit, and find
// free stops at the first free one, or scans the whole range when the table is full.
// The limit is the configured cluster limit saturated to MAX_CLUSTERS. A new
// item is taken while one result still waits at the output; a second finished
// result is parked in a hold register and input stalls until it moves on.
module fat12_cluster_table_engine #(
  parameter int MAX_CLUSTERS = fat12_cte_pkg::DEF_MAX_CLUSTERS,
  parameter int TABLE_BYTES  = fat12_cte_pkg::DEF_TABLE_BYTES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  fat12_cte_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output fat12_cte_pkg::out_item_t out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [fat12_cte_pkg::ADDR_W-1:0] cfg_data
);

  localparam int Rows = (TABLE_BYTES + 1) / 2;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [fat12_cte_pkg::ADDR_W-1:0] MaxLim   = 13'(MAX_CLUSTERS);
  localparam logic [fat12_cte_pkg::ADDR_W-1:0] TableLim = 13'(TABLE_BYTES);

  fat12_cte_pkg::state_t state, state_next;

  logic [12:0] cluster_limit;
  logic [12:0] scan_lim;
  logic [12:0] scan_index;
  logic [12:0] free_counter;

  // byte banks
  logic [7:0] bank0 [Rows];
  logic [7:0] bank1 [Rows];
  logic [7:0] rd0, rd1;

  // read side
  logic        rd_en;
  logic [11:0] rd_c;
  logic [12:0] ent_a;
  logic [11:0] ent_row, row0;
  logic        lo_ok, hi_ok;

  // captured with each read and each accepted item
  logic [2:0]  cmd_q;
  logic [11:0] val_q;
  logic [11:0] row0_q, row1_q;
  logic        swap_q, odd_q, lo_ok_q, hi_ok_q;
  logic        rd_valid_q;
  logic [11:0] rd_idx_q;

  logic [7:0]  lo_b, hi_b, lo_new, hi_new;
  logic [11:0] entry;
  logic        hit;
  logic        issue;

  // write side
  logic        wr0_en, wr1_en;
  logic [11:0] wr0_row, wr1_row;
  logic [7:0]  wr0_data, wr1_data;
  logic        load_en, load_ok;

  logic accept;
  logic fin_valid;
  fat12_cte_pkg::out_item_t fin_data;
  logic hold_valid;
  fat12_cte_pkg::out_item_t hold_data;
  logic out_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == fat12_cte_pkg::S_IDLE) && !hold_valid;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign scan_lim  = (cluster_limit > MaxLim) ? MaxLim : cluster_limit;
  assign issue     = (state == fat12_cte_pkg::S_SCAN) && (scan_index < scan_lim);

  // entry byte address is cluster * 3 / 2
  always_comb begin
    rd_c    = (state == fat12_cte_pkg::S_SCAN) ? scan_index[11:0] : in_data.cluster;
    ent_a   = {1'b0, rd_c} + {2'b00, rd_c[11:1]};
    ent_row = ent_a[12:1];
    row0    = ent_a[0] ? (ent_row + 12'd1) : ent_row;
    lo_ok   = ent_a < TableLim;
    hi_ok   = (ent_a + 13'd1) < TableLim;
  end

  always_comb begin
    lo_b   = lo_ok_q ? (swap_q ? rd1 : rd0) : 8'h00;
    hi_b   = hi_ok_q ? (swap_q ? rd0 : rd1) : 8'h00;
    entry  = odd_q ? {hi_b, lo_b[7:4]} : {hi_b[3:0], lo_b};
    hit    = rd_valid_q && (entry == 12'h000);
    // nibble merge keeps the neighbor entry's half byte
    lo_new = odd_q ? {val_q[3:0], lo_b[3:0]} : val_q[7:0];
    hi_new = odd_q ? val_q[11:4] : {hi_b[7:4], val_q[11:8]};
  end

  always_comb begin
    load_en = accept && (in_data.command == fat12_cte_pkg::CMD_LOAD);
    load_ok = in_data.byte_addr < TableLim;
    if (state == fat12_cte_pkg::S_ENTRY) begin
      wr0_row  = row0_q;
      wr1_row  = row1_q;
      wr0_data = swap_q ? hi_new : lo_new;
      wr1_data = swap_q ? lo_new : hi_new;
      wr0_en   = (cmd_q == fat12_cte_pkg::CMD_WRITE) && (swap_q ? hi_ok_q : lo_ok_q);
      wr1_en   = (cmd_q == fat12_cte_pkg::CMD_WRITE) && (swap_q ? lo_ok_q : hi_ok_q);
    end else begin
      wr0_row  = in_data.byte_addr[12:1];
      wr1_row  = in_data.byte_addr[12:1];
      wr0_data = in_data.byte_data;
      wr1_data = in_data.byte_data;
      wr0_en   = load_en && load_ok && !in_data.byte_addr[0];
      wr1_en   = load_en && load_ok && in_data.byte_addr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr0_en) begin
      bank0[wr0_row[RowW-1:0]] <= wr0_data;
    end
    if (rd_en) begin
      rd0 <= bank0[row0[RowW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      bank1[wr1_row[RowW-1:0]] <= wr1_data;
    end
    if (rd_en) begin
      rd1 <= bank1[ent_row[RowW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row0_q  <= row0;
      row1_q  <= ent_row;
      swap_q  <= ent_a[0];
      odd_q   <= rd_c[0];
      lo_ok_q <= lo_ok;
      hi_ok_q <= hi_ok;
      rd_idx_q <= rd_c;
    end
    if (accept) begin
      cmd_q <= in_data.command;
      val_q <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_limit <= fat12_cte_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      cluster_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fat12_cte_pkg::S_IDLE;
      scan_index   <= '0;
      free_counter <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      state      <= state_next;
      rd_valid_q <= issue;
      if (accept) begin
        scan_index   <= fat12_cte_pkg::FIRST_DATA_CLUSTER;
        free_counter <= '0;
      end else begin
        if (issue) begin
          scan_index <= scan_index + 13'd1;
        end
        if (state == fat12_cte_pkg::S_SCAN && hit) begin
          free_counter <= free_counter + 13'd1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    fin_valid  = 1'b0;
    fin_data   = '0;
    rd_en      = 1'b0;
    unique case (state)
      fat12_cte_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data.command)
            fat12_cte_pkg::CMD_READ, fat12_cte_pkg::CMD_WRITE: begin
              rd_en      = 1'b1;
              state_next = fat12_cte_pkg::S_ENTRY;
            end
            fat12_cte_pkg::CMD_FIND, fat12_cte_pkg::CMD_COUNT: begin
              state_next = fat12_cte_pkg::S_SCAN;
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      fat12_cte_pkg::S_ENTRY: begin
        fin_valid  = 1'b1;
        state_next = fat12_cte_pkg::S_IDLE;
        if (cmd_q == fat12_cte_pkg::CMD_READ) begin
          fin_data.next_cluster = entry;
          fin_data.end_of_chain = entry >= fat12_cte_pkg::EOC_MIN;
        end
      end
      fat12_cte_pkg::S_SCAN: begin
        rd_en = issue;
        if (cmd_q == fat12_cte_pkg::CMD_FIND && hit) begin
          fin_valid              = 1'b1;
          fin_data.found_cluster = rd_idx_q;
          state_next             = fat12_cte_pkg::S_IDLE;
        end else if (!issue && !rd_valid_q) begin
          // range exhausted and the last read evaluated
          fin_valid  = 1'b1;
          state_next = fat12_cte_pkg::S_IDLE;
          if (cmd_q == fat12_cte_pkg::CMD_FIND) begin
            fin_data.status = 1'b1;
          end else begin
            fin_data.free_count = free_counter;
          end
        end
      end
      default: begin
        state_next = fat12_cte_pkg::S_IDLE;
      end
    endcase
  end

  // output register with one hold stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        out_data   <= hold_data;
        hold_valid <= 1'b0;
      end else if (fin_valid) begin
        out_valid <= 1'b1;
        out_data  <= fin_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      hold_valid <= 1'b1;
      hold_data  <= fin_data;
    end
  end

endmodule

// ----- rtl/core/fat12_cte_checker.sv -----
// port-level checks for the fat12 cluster table engine, bound to the top level
module fat12_cte_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input fat12_cte_pkg::out_item_t out_data
);

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output not empty or input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result item changed or dropped");

  a_eoc_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.end_of_chain) |->
      (out_data.next_cluster >= fat12_cte_pkg::EOC_MIN))
    else $error("end of chain flagged below the reserved range");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |->
      (out_data.found_cluster == 12'h000 && out_data.free_count == 13'h0000 &&
       out_data.next_cluster == 12'h000))
    else $error("disk full item carries other fields");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.found_cluster != 12'h000) |->
      (out_data.found_cluster >= 12'd2 && !out_data.status &&
       out_data.free_count == 13'h0000))
    else $error("found cluster below first data cluster or mixed with other fields");

endmodule

bind fat12_cluster_table_engine fat12_cte_checker u_fat12_cte_checker (.*);

// ----- test/fat12_table_checker.sv -----
// checker for the fat12 cluster table engine: mirrors the table and compares every result
module fat12_table_checker
  import fat12_cte_pkg::*;
#(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int TABLE_BYTES  = DEF_TABLE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data,
  output int                waiting,
  output int                errors,
  output int                full_answers
);

  bit [7:0]             fat_bytes [TABLE_BYTES];
  int                   limit_reg = int'(LIMIT_RESET);
  logic [CLUSTER_W-1:0] last_found;
  logic [COUNT_W-1:0]   last_count;
  out_item_t            answers_due [$];

  function automatic logic [7:0] byte_at(int a);
    return (a < TABLE_BYTES) ? fat_bytes[a] : 8'h00;
  endfunction

  function automatic void store_byte(int a, logic [7:0] d);
    if (a < TABLE_BYTES) fat_bytes[a] = d;
  endfunction

  // entry c starts at byte c*3/2; odd entries start on the high nibble
  function automatic logic [CLUSTER_W-1:0] entry_at(int c);
    int a;
    logic [7:0] lo, hi;
    a = c * 3 / 2;
    lo = byte_at(a);
    hi = byte_at(a + 1);
    return c[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
  endfunction

  function automatic void put_entry(int c, logic [CLUSTER_W-1:0] v);
    int a;
    logic [7:0] old;
    a = c * 3 / 2;
    if (c[0]) begin
      old = byte_at(a);
      store_byte(a, {v[3:0], old[3:0]});
      store_byte(a + 1, v[11:4]);
    end else begin
      old = byte_at(a + 1);
      store_byte(a, v[7:0]);
      store_byte(a + 1, {old[7:4], v[11:8]});
    end
  endfunction

  function automatic out_item_t fat_command(in_item_t it);
    out_item_t r;
    int lim, c;
    r = '0;
    lim = (limit_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : limit_reg;
    case (it.command)
      CMD_LOAD: store_byte(int'(it.byte_addr), it.byte_data);
      CMD_READ: begin
        r.next_cluster = entry_at(int'(it.cluster));
        r.end_of_chain = (r.next_cluster >= EOC_MIN);
      end
      CMD_WRITE: put_entry(int'(it.cluster), it.value);
      CMD_FIND: begin
        r.status = 1'b1;
        for (c = int'(FIRST_DATA_CLUSTER); c < lim; c++) begin
          if (entry_at(c) == '0) begin
            r.found_cluster = CLUSTER_W'(c);
            r.status = 1'b0;
            break;
          end
        end
        last_found = r.found_cluster;
      end
      CMD_COUNT: begin
        for (c = int'(FIRST_DATA_CLUSTER); c < lim; c++) begin
          if (entry_at(c) == '0) r.free_count = r.free_count + 1'b1;
        end
        last_count = r.free_count;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      answers_due.delete();
      limit_reg = int'(LIMIT_RESET);
      last_found = '0;
      last_count = '0;
      errors = 0;
      full_answers = 0;
    end else begin
      // results leave before new items enter, so a same-edge pair stays in order
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $error("result arrived with no command outstanding");
        end else begin
          want = answers_due.pop_front();
          if (want.status) full_answers++;
          if (out_data.next_cluster !== want.next_cluster) begin
            errors++;
            $error("next_cluster: expected %0h, got %0h", want.next_cluster,
                   out_data.next_cluster);
          end
          if (out_data.end_of_chain !== want.end_of_chain) begin
            errors++;
            $error("end_of_chain: expected %0h, got %0h", want.end_of_chain,
                   out_data.end_of_chain);
          end
          if (out_data.found_cluster !== want.found_cluster) begin
            errors++;
            $error("found_cluster: expected %0h, got %0h", want.found_cluster,
                   out_data.found_cluster);
          end
          if (out_data.free_count !== want.free_count) begin
            errors++;
            $error("free_count: expected %0h, got %0h", want.free_count,
                   out_data.free_count);
          end
          if (out_data.status !== want.status) begin
            errors++;
            $error("status: expected %0h, got %0h", want.status, out_data.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = int'(cfg_data);
      if (in_valid && in_ready) answers_due.push_back(fat_command(in_data));
    end
    waiting = answers_due.size();
  end

endmodule

// ----- test/tb_fat12_cluster_table_engine.sv -----
// testbench top for the fat12 cluster table engine: stimulus, idling and verdict
module tb_fat12_cluster_table_engine;
  import fat12_cte_pkg::*;

  localparam int N_CLUSTERS  = DEF_MAX_CLUSTERS;
  localparam int N_BYTES     = DEF_TABLE_BYTES;
  localparam int QUIET_LIMIT = 30000;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 72;
  localparam int CMD_SPARE_FIRST = int'(CMD_COUNT) + 1;
  localparam int CMD_LAST        = (1 << CMD_W) - 1;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid, in_ready;
  in_item_t          in_data;
  logic              out_valid, out_ready;
  out_item_t         out_data;
  logic              cfg_valid, cfg_ready;
  logic [ADDR_W-1:0] cfg_data;

  int waiting, errors, full_answers;
  int idle_pct, ready_hold, quiet, sent, settings, limit_now;
  int per_cmd [1 << CMD_W];
  int phase_lim [PHASES];
  logic [CLUSTER_W-1:0] plan [N_CLUSTERS];

  fat12_cluster_table_engine #(
    .MAX_CLUSTERS(N_CLUSTERS),
    .TABLE_BYTES (N_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  fat12_table_checker #(
    .MAX_CLUSTERS(N_CLUSTERS),
    .TABLE_BYTES (N_BYTES)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .waiting     (waiting),
    .errors      (errors),
    .full_answers(full_answers)
  );

  always #2 clk = ~clk;

  // result side stalls in bursts, at the percentage set by idle_pct
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // for loads a is the byte address and b the byte, otherwise cluster and entry value
  task automatic issue(input logic [CMD_W-1:0] cmd, input int a, input int b);
    in_item_t it;
    int gap;
    it.command   = cmd;
    it.cluster   = CLUSTER_W'($urandom);
    it.value     = CLUSTER_W'($urandom);
    it.byte_addr = ADDR_W'($urandom);
    it.byte_data = 8'($urandom);
    if (cmd == CMD_LOAD) begin
      it.byte_addr = ADDR_W'(a);
      it.byte_data = 8'(b);
    end else begin
      it.cluster = CLUSTER_W'(a);
      it.value   = CLUSTER_W'(b);
    end
    gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    per_cmd[cmd]++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic set_limit(input int lim);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= ADDR_W'(lim);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_now = lim;
    settings++;
  endtask

  // each pair of entries packs into three table bytes
  task automatic load_plan(input int pairs);
    int k;
    logic [CLUSTER_W-1:0] e0, e1;
    for (k = 0; k < pairs; k++) begin
      e0 = plan[2 * k];
      e1 = plan[2 * k + 1];
      issue(CMD_LOAD, 3 * k, e0[7:0]);
      issue(CMD_LOAD, 3 * k + 1, {e1[3:0], e0[11:8]});
      issue(CMD_LOAD, 3 * k + 2, e1[11:4]);
    end
  endtask

  function automatic int scan_end();
    return (limit_now > N_CLUSTERS) ? N_CLUSTERS : limit_now;
  endfunction

  function automatic int entry_value();
    int r;
    r = $urandom_range(15);
    if (r < 2) return 0;
    if (r == 2) return $urandom_range(int'(EOC_MIN), 12'hFFF);
    return $urandom_range(N_CLUSTERS - 1);
  endfunction

  // mostly clusters inside the scan window, so scans see the writes
  function automatic int pick_cluster();
    int lim;
    lim = scan_end();
    if (lim > 3 && $urandom_range(9) < 7) return $urandom_range(2, lim - 1);
    return $urandom_range(N_CLUSTERS - 1);
  endfunction

  task automatic random_sequence();
    int r, n, i, c, lim;
    int chain [5];
    r = $urandom_range(99);
    lim = scan_end();
    if (r < 20) begin
      // build a cluster chain ending in an end-of-chain mark, then walk it
      n = $urandom_range(2, 5);
      for (i = 0; i < n; i++) chain[i] = pick_cluster();
      for (i = 0; i < n - 1; i++) issue(CMD_WRITE, chain[i], chain[i + 1]);
      issue(CMD_WRITE, chain[n - 1], $urandom_range(int'(EOC_MIN), 12'hFFF));
      for (i = 0; i < n; i++) issue(CMD_READ, chain[i], $urandom);
    end else if (r < 30) begin
      issue(CMD_WRITE, pick_cluster(), 0);
      issue(CMD_FIND, $urandom, $urandom);
      if (lim <= 1024 || $urandom_range(3) == 0) issue(CMD_COUNT, $urandom, $urandom);
    end else if (r < 38 && lim <= 48) begin
      // claim the whole window until the disk is full, then free one entry
      for (c = 2; c < lim; c++) issue(CMD_WRITE, c, $urandom_range(1, N_CLUSTERS - 1));
      issue(CMD_FIND, $urandom, $urandom);
      issue(CMD_COUNT, $urandom, $urandom);
      if (lim > 2) begin
        issue(CMD_WRITE, $urandom_range(2, lim - 1), 0);
        issue(CMD_FIND, $urandom, $urandom);
      end
    end else if (r < 55) begin
      issue(CMD_READ, $urandom_range(N_CLUSTERS - 1), $urandom);
    end else if (r < 70) begin
      issue(CMD_WRITE, pick_cluster(), entry_value());
    end else if (r < 78) begin
      issue(CMD_FIND, $urandom, $urandom);
    end else if (r < 84) begin
      if (lim <= 1024 || $urandom_range(3) == 0) issue(CMD_COUNT, $urandom, $urandom);
      else issue(CMD_FIND, $urandom, $urandom);
    end else if (r < 92) begin
      issue(CMD_LOAD, $urandom_range((1 << ADDR_W) - 1), $urandom);
    end else begin
      issue(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_LAST)), $urandom, $urandom);
    end
  endtask

  initial begin
    int p, goal, k;
    bit paused;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    ready_hold = 0;
    idle_pct = 0;
    quiet = 0;
    sent = 0;
    settings = 0;
    limit_now = int'(LIMIT_RESET);
    for (k = 0; k <= CMD_LAST; k++) per_cmd[k] = 0;
    phase_lim = '{4096, 8191, 2, $urandom_range(3, 64), 4097, $urandom_range(65, 4095),
                  0, $urandom_range(3, 40), 1, 4095, 4096};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    idle_pct = 15;

    // hand-built window of six entries: free, end-of-chain bounds, plain values
    set_limit(6);
    plan[0] = 12'h000;
    plan[1] = 12'hFFF;
    plan[2] = EOC_MIN;
    plan[3] = 12'h000;
    plan[4] = EOC_MIN - 1'b1;
    plan[5] = 12'hABC;
    load_plan(3);
    issue(CMD_LOAD, (1 << ADDR_W) - 1, 8'hA5);
    issue(CMD_LOAD, N_BYTES, 8'h5A);
    issue(CMD_READ, 0, $urandom);
    issue(CMD_READ, 1, $urandom);
    issue(CMD_READ, 2, $urandom);
    issue(CMD_READ, 4, $urandom);
    issue(CMD_FIND, $urandom, $urandom);
    issue(CMD_COUNT, $urandom, $urandom);
    issue(CMD_WRITE, 3, 12'h123);
    issue(CMD_WRITE, 2, 0);
    issue(CMD_READ, 3, $urandom);
    issue(CMD_READ, 2, $urandom);
    issue(CMD_FIND, $urandom, $urandom);
    for (k = CMD_SPARE_FIRST; k <= CMD_LAST; k++) issue(CMD_W'(k), $urandom, $urandom);
    set_limit(2);
    issue(CMD_FIND, $urandom, $urandom);
    issue(CMD_COUNT, $urandom, $urandom);

    // fill the whole table so every later read hits loaded bytes
    for (k = 0; k < N_CLUSTERS; k++)
      plan[k] = ($urandom_range(7) == 0) ? '0 : CLUSTER_W'(entry_value());
    load_plan(N_CLUSTERS / 2);

    for (p = 0; p < PHASES; p++) begin
      set_limit(phase_lim[p]);
      idle_pct = (p == PHASES - 1 || $urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
      if (p == 0) begin
        issue(CMD_WRITE, N_CLUSTERS - 1, 12'hFFF);
        issue(CMD_READ, N_CLUSTERS - 1, $urandom);
        issue(CMD_WRITE, N_CLUSTERS - 2, 0);
        issue(CMD_READ, N_CLUSTERS - 1, $urandom);
        issue(CMD_READ, N_CLUSTERS - 2, $urandom);
      end
      goal = sent + PHASE_ITEMS;
      paused = 1'b0;
      while (sent < goal) begin
        // hold the sender once per phase until every answer is back
        if (!paused && sent >= goal - PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        random_sequence();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    $display("%0d items over %0d limit settings: %0d loads, %0d reads, %0d writes,",
             sent, settings, per_cmd[CMD_LOAD], per_cmd[CMD_READ], per_cmd[CMD_WRITE]);
    $display("%0d find free (%0d on a full disk), %0d count free, %0d spare codes",
             per_cmd[CMD_FIND], full_answers, per_cmd[CMD_COUNT],
             sent - per_cmd[CMD_LOAD] - per_cmd[CMD_READ] - per_cmd[CMD_WRITE]
             - per_cmd[CMD_FIND] - per_cmd[CMD_COUNT]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fat12_cte_pkg.sv
rtl/core/fat12_cluster_table_engine.sv
rtl/core/fat12_cte_checker.sv
test/fat12_table_checker.sv
test/tb_fat12_cluster_table_engine.sv
